// ===== rtl/c2e_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2e_pkg
// Shared widths, types and tables of the normalized 3x3 convolution block.
// ----------------------------------------------------------------------------
package c2e_pkg;

  localparam int unsigned MAX_WIDTH    = 1024;
  localparam int unsigned MASK_SIZE    = 3;
  localparam int unsigned HEIGHT_LIMIT = 1024;

  localparam int unsigned ADDR_W    = $clog2(MAX_WIDTH);
  localparam int unsigned POS_W     = 11;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned ROW_W     = MASK_SIZE * COEF_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned FILT_W    = 12;

  // widest image row: the line store depth, capped at what the position counters can express
  localparam int unsigned WIDTH_CAP = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;

  localparam int unsigned PSUM_W      = 26;
  localparam int unsigned ACC_W       = 28;
  localparam int unsigned FRAC_BITS   = 12;
  localparam int unsigned MAG_W       = 15;
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned RECIP_W     = 21;
  localparam int unsigned PROD_W      = MAG_W + RECIP_W;
  localparam int unsigned QMAG_W      = PROD_W - RECIP_SHIFT;
  localparam int unsigned TAPS_W      = 4;

  localparam int unsigned FILT_POS_MAX = 2047;
  localparam int unsigned FILT_NEG_MAX = 2048;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_COEF0  = 3'd2,
    REG_COEF1  = 3'd3,
    REG_COEF2  = 3'd4
  } cfg_reg_t;

  typedef logic [MASK_SIZE-1:0]             mask_t;
  typedef logic [MASK_SIZE-1:0][PIX_W-1:0]  pix_col_t;
  typedef logic [MASK_SIZE-1:0][COEF_W-1:0] coef_col_t;

  typedef struct packed {
    logic              valid;
    logic              fend;
    logic [TAPS_W-1:0] taps;
  } tag_t;

  function automatic logic [1:0] count3(input mask_t m);
    logic [1:0] c;
    c = '0;
    for (int i = 0; i < MASK_SIZE; i++) begin
      c = c + {1'b0, m[i]};
    end
    return c;
  endfunction

  // ceil(2^20 / n); zero taps give a zero result
  function automatic logic [RECIP_W-1:0] recip(input logic [TAPS_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = 21'd1048576;
      4'd2:    r = 21'd524288;
      4'd3:    r = 21'd349526;
      4'd4:    r = 21'd262144;
      4'd5:    r = 21'd209716;
      4'd6:    r = 21'd174763;
      4'd7:    r = 21'd149797;
      4'd8:    r = 21'd131072;
      4'd9:    r = 21'd116509;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/c2e_line_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2e_line_buf
// Two-row line store with registered reads and a write-to-read bypass.
// ----------------------------------------------------------------------------
module c2e_line_buf (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [c2e_pkg::ADDR_W-1:0] rd_addr,
  input  logic                      wr_en,
  input  logic [c2e_pkg::ADDR_W-1:0] wr_addr,
  input  logic [c2e_pkg::PIX_W-1:0]  wr_px,
  output logic [c2e_pkg::PIX_W-1:0]  top,
  output logic [c2e_pkg::PIX_W-1:0]  mid
);
  import c2e_pkg::*;

  logic [PIX_W-1:0] top_mem [MAX_WIDTH];
  logic [PIX_W-1:0] mid_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_top;
  logic [PIX_W-1:0] rd_mid;
  logic [PIX_W-1:0] byp_top;
  logic [PIX_W-1:0] byp_mid;
  logic             byp;

  // older row moves up, new pixel takes its place
  always_ff @(posedge clk) begin
    if (wr_en) begin
      top_mem[wr_addr] <= mid;
      mid_mem[wr_addr] <= wr_px;
    end
    if (en) begin
      rd_top  <= top_mem[rd_addr];
      rd_mid  <= mid_mem[rd_addr];
      byp_top <= mid;
      byp_mid <= wr_px;
    end
  end

  // one-pixel rows read the column being written in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (en) begin
      byp <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign top = byp ? byp_top : rd_top;
  assign mid = byp ? byp_mid : rd_mid;

endmodule

// ===== rtl/c2e_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2e_cell
// One window column: holds three taps, passes them left, forms its weighted sum.
// ----------------------------------------------------------------------------
module c2e_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             shift,
  input  logic                             calc,
  input  c2e_pkg::pix_col_t                pix_in,
  output c2e_pkg::pix_col_t                pix_out,
  input  c2e_pkg::coef_col_t               coef,
  input  c2e_pkg::mask_t                   rmask,
  input  logic                             cvalid,
  output logic signed [c2e_pkg::PSUM_W-1:0] psum
);
  import c2e_pkg::*;

  pix_col_t                     pix;
  logic signed [PIX_W+COEF_W:0] prod [MASK_SIZE];
  logic signed [PSUM_W-1:0]     sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix <= '0;
    end else if (shift) begin
      pix <= pix_in;
    end
  end

  assign pix_out = pix;

  always_comb begin
    sum = '0;
    for (int r = 0; r < MASK_SIZE; r++) begin
      prod[r] = $signed({1'b0, pix[r]}) * $signed(coef[r]);
      if (rmask[r] && cvalid) begin
        sum = sum + PSUM_W'(prod[r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (calc) begin
      psum <= sum;
    end
  end

endmodule

// ===== rtl/c2e_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2e_norm
// Divides the weighted sum by 4096 times the tap count, truncating toward zero.
// ----------------------------------------------------------------------------
module c2e_norm (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  c2e_pkg::tag_t                    tag_in,
  input  logic signed [c2e_pkg::ACC_W-1:0]  acc,
  output logic                             res_valid,
  output logic signed [c2e_pkg::FILT_W-1:0] res_value,
  output logic                             res_fend
);
  import c2e_pkg::*;

  tag_t               tag5;
  tag_t               tag6;
  logic               neg5;
  logic               neg6;
  logic [MAG_W-1:0]   mag5;
  logic [RECIP_W-1:0] recip5;
  logic [PROD_W-1:0]  prod6;
  logic [ACC_W-1:0]   acc_abs;
  logic [QMAG_W-1:0]  qm;
  logic signed [FILT_W-1:0] value;

  assign acc_abs = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag5      <= '0;
      tag6      <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      tag5      <= tag_in;
      tag6      <= tag5;
      res_valid <= tag6.valid;
    end
  end

  // sign-magnitude: drop the Q12 fraction, then divide by taps via reciprocal
  always_ff @(posedge clk) begin
    if (en) begin
      neg5      <= acc[ACC_W-1];
      mag5      <= acc_abs[FRAC_BITS +: MAG_W];
      recip5    <= recip(tag_in.taps);
      neg6      <= neg5;
      prod6     <= PROD_W'(mag5) * PROD_W'(recip5);
      res_value <= value;
      res_fend  <= tag6.fend;
    end
  end

  always_comb begin
    qm = prod6[RECIP_SHIFT +: QMAG_W];
    if (neg6) begin
      if (qm > QMAG_W'(FILT_NEG_MAX)) begin
        value = -FILT_W'(FILT_NEG_MAX);
      end else begin
        value = -FILT_W'(qm);
      end
    end else if (qm > QMAG_W'(FILT_POS_MAX)) begin
      value = FILT_W'(FILT_POS_MAX);
    end else begin
      value = FILT_W'(qm);
    end
  end

endmodule

// ===== rtl/conv2d_edge_normalized.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_edge_normalized
// Streaming 3x3 convolution of grey pixels, normalized by the in-image tap count.
//
// Pixels come in raster order, one beat per clock, and the block keeps that
// rate for as long as the result side takes beats: every stage advances
// together, so throughput is one item per cycle and a stalled result holds
// the whole pipe and the input. The result for pixel (r,c) comes out on the
// beat caused by the item at (r+1,c+1), and that beat passes in turn through
// the line store read, the window shift, the per-column products in the
// chain of three window cells, the column sum, and the divide by the tap
// count (a reciprocal multiply) with its magnitude, product and result
// registers. After the last pixel of a frame send width+1 drain beats
// (command = 1) to flush the remaining results. The line store needs
// no clearing pass after reset. Write configuration only while the block is
// idle; cfg_ready is always high.
// ----------------------------------------------------------------------------
module conv2d_edge_normalized (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic                                 command,
  input  logic [c2e_pkg::PIX_W-1:0]             pixel,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [c2e_pkg::FILT_W-1:0]     filtered,
  output logic                                 frame_end,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [c2e_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [c2e_pkg::ROW_W-1:0]             cfg_data
);
  import c2e_pkg::*;

  logic [POS_W-1:0] image_width;
  logic [POS_W-1:0] image_height;
  logic [ROW_W-1:0] coef_row [MASK_SIZE];
  logic [POS_W-1:0] w_eff;
  logic [POS_W-1:0] h_eff;

  logic [POS_W-1:0] in_row, in_col, out_row, out_col;
  logic [POS_W-1:0] in_row_next, in_col_next, out_row_next, out_col_next;
  logic [POS_W:0]   in_col_inc, out_row_inc, out_col_inc;
  logic             adv, accept, emit, fend, wrap_in;
  mask_t            rmask, cmask;
  logic [ADDR_W-1:0] rd_addr;

  logic              v1, v2, v3, v4;
  logic              emit1, fend1, fend2, fend3, fend4;
  mask_t             rmask1, cmask1, rmask2, cmask2;
  logic [PIX_W-1:0]  px1;
  logic [ADDR_W-1:0] addr1;
  logic [TAPS_W-1:0] taps3, taps4;
  logic [PIX_W-1:0]  top, mid;
  logic signed [ACC_W-1:0]  acc_sum, acc4;
  logic signed [PSUM_W-1:0] psum [MASK_SIZE];
  pix_col_t          col_pix [MASK_SIZE+1];
  tag_t              tag4;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= POS_W'(640);
      image_height <= POS_W'(480);
      for (int i = 0; i < MASK_SIZE; i++) begin
        coef_row[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  image_width  <= cfg_data[POS_W-1:0];
        REG_HEIGHT: image_height <= cfg_data[POS_W-1:0];
        REG_COEF0:  coef_row[0]  <= cfg_data;
        REG_COEF1:  coef_row[1]  <= cfg_data;
        REG_COEF2:  coef_row[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      w_eff = POS_W'(1);
    end else if (32'(image_width) > WIDTH_CAP) begin
      w_eff = POS_W'(WIDTH_CAP);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = POS_W'(1);
    end else if (32'(image_height) > HEIGHT_LIMIT) begin
      h_eff = POS_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = image_height;
    end
  end

  assign adv        = !result_valid || !result_stall;
  assign item_stall = !adv;
  assign accept     = item_valid && adv;

  assign in_col_inc  = {1'b0, in_col} + (POS_W + 1)'(1);
  assign out_row_inc = {1'b0, out_row} + (POS_W + 1)'(1);
  assign out_col_inc = {1'b0, out_col} + (POS_W + 1)'(1);
  assign rd_addr     = (32'(in_col) < MAX_WIDTH) ? ADDR_W'(in_col) : ADDR_W'(MAX_WIDTH - 1);

  // position bookkeeping is settled at accept time for every item
  always_comb begin
    in_row_next  = in_row;
    in_col_next  = in_col;
    out_row_next = out_row;
    out_col_next = out_col;
    emit    = (in_row >= POS_W'(2)) || ((in_row == POS_W'(1)) && (in_col != '0));
    wrap_in = in_col_inc >= {1'b0, w_eff};
    fend    = (out_row_inc >= {1'b0, h_eff}) && (out_col_inc >= {1'b0, w_eff});
    rmask[0] = (out_row != '0) && ((out_row - POS_W'(1)) < h_eff);
    rmask[1] = out_row < h_eff;
    rmask[2] = out_row_inc < {1'b0, h_eff};
    cmask[0] = (out_col != '0) && ((out_col - POS_W'(1)) < w_eff);
    cmask[1] = out_col < w_eff;
    cmask[2] = out_col_inc < {1'b0, w_eff};
    if (accept) begin
      if (wrap_in) begin
        in_col_next = '0;
        in_row_next = in_row + POS_W'(1);
      end else begin
        in_col_next = in_col_inc[POS_W-1:0];
      end
      if (emit) begin
        if (fend) begin
          in_row_next  = '0;
          in_col_next  = '0;
          out_row_next = '0;
          out_col_next = '0;
        end else if (out_col_inc >= {1'b0, w_eff}) begin
          out_col_next = '0;
          out_row_next = out_row + POS_W'(1);
        end else begin
          out_col_next = out_col_inc[POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
    end else begin
      in_row  <= in_row_next;
      in_col  <= in_col_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= accept;
      v2 <= v1 && emit1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      emit1  <= emit;
      fend1  <= fend;
      rmask1 <= rmask;
      cmask1 <= cmask;
      px1    <= command ? '0 : pixel;
      addr1  <= rd_addr;
      rmask2 <= rmask1;
      cmask2 <= cmask1;
      fend2  <= fend1;
      fend3  <= fend2;
      taps3  <= {2'b0, count3(rmask2)} * {2'b0, count3(cmask2)};
      fend4  <= fend3;
      taps4  <= taps3;
      acc4   <= acc_sum;
    end
  end

  c2e_line_buf u_line_buf (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .rd_addr (rd_addr),
    .wr_en   (v1 && adv),
    .wr_addr (addr1),
    .wr_px   (px1),
    .top     (top),
    .mid     (mid)
  );

  // new column enters at the right cell and walks left
  always_comb begin
    col_pix[MASK_SIZE][0] = top;
    col_pix[MASK_SIZE][1] = mid;
    col_pix[MASK_SIZE][2] = px1;
  end

  for (genvar k = 0; k < MASK_SIZE; k++) begin : g_cell
    coef_col_t cell_coef;

    always_comb begin
      for (int r = 0; r < MASK_SIZE; r++) begin
        cell_coef[r] = coef_row[r][k*COEF_W +: COEF_W];
      end
    end

    c2e_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (v1 && adv),
      .calc    (adv),
      .pix_in  (col_pix[k+1]),
      .pix_out (col_pix[k]),
      .coef    (cell_coef),
      .rmask   (rmask2),
      .cvalid  (cmask2[k]),
      .psum    (psum[k])
    );
  end

  always_comb begin
    acc_sum = '0;
    for (int k = 0; k < MASK_SIZE; k++) begin
      acc_sum = acc_sum + ACC_W'(psum[k]);
    end
  end

  assign tag4 = '{valid: v4, fend: fend4, taps: taps4};

  c2e_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .tag_in    (tag4),
    .acc       (acc4),
    .res_valid (result_valid),
    .res_value (filtered),
    .res_fend  (frame_end)
  );

endmodule

// ===== rtl/c2e_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2e_checker
// Port-level checks of the normalized convolution block, bound to the top level.
// ----------------------------------------------------------------------------
module c2e_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             item_valid,
  input logic                             item_stall,
  input logic                             result_valid,
  input logic                             result_stall,
  input logic signed [c2e_pkg::FILT_W-1:0] filtered,
  input logic                             frame_end
);
  import c2e_pkg::*;

  // a waiting result beat keeps its value
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(filtered) && $stable(frame_end))
    else $error("result beat changed while stalled");

  // input only backs up behind a stalled result
  assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled with no stalled result");

  // handshake outputs are always known once out of reset
  assert property (@(posedge clk) disable iff (rst)
    !$isunknown({item_stall, result_valid}))
    else $error("unknown handshake output");

  // reset empties the pipe
  assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result beat right after reset");

endmodule

bind conv2d_edge_normalized c2e_checker u_c2e_checker (.*);

// ===== dv/tb_conv2d_edge_normalized.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_conv2d_edge_normalized
// Self-checking bench for the edge-normalized 3x3 convolution block.
//
// Frames are streamed pixel by pixel with random gaps on the input side and
// random stalls on the result side. A bit-exact software copy of the block
// predicts every result as its input beat is accepted, and each result beat
// is compared against the oldest prediction. Sizes and mask rows are changed
// between frames only, once the pipe has drained.
// ----------------------------------------------------------------------------
module tb_conv2d_edge_normalized;
  import c2e_pkg::*;

  localparam int  CLK_HALF      = 6;
  localparam int  RESET_CYCLES  = 12;
  localparam int  IDLE_PCT      = 16;
  localparam int  SETTLE_CYCLES = 20;
  localparam int  RANDOM_ITEMS  = 400;
  localparam int  CYCLE_LIMIT   = 200000;
  localparam int  PRINT_LIMIT   = 100;
  localparam logic CMD_PIXEL    = 1'b0;
  localparam logic CMD_DRAIN    = 1'b1;

  typedef struct packed {
    logic signed [FILT_W-1:0] filtered;
    logic                     frame_end;
  } conv_result_t;

  logic                     clk;
  logic                     rst          = 1'b1;
  logic                     item_valid   = 1'b0;
  logic                     item_stall;
  logic                     command      = 1'b0;
  logic [PIX_W-1:0]         pixel        = '0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  logic signed [FILT_W-1:0] filtered;
  logic                     frame_end;
  logic                     cfg_valid    = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index    = '0;
  logic [ROW_W-1:0]         cfg_data     = '0;

  // software copy of the block
  logic [POS_W-1:0] cfg_width  = 11'd640;
  logic [POS_W-1:0] cfg_height = 11'd480;
  logic [ROW_W-1:0] coef_rows [3];
  logic [PIX_W-1:0] row_buf [2*MAX_WIDTH];
  logic [PIX_W-1:0] win [9];
  int unsigned      in_row, in_col, out_row, out_col;

  conv_result_t expected_results [$];
  int unsigned  items_sent;
  int unsigned  mismatch_count;
  int unsigned  cycle_count;
  bit           quiet;

  conv2d_edge_normalized i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .command      (command),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .filtered     (filtered),
    .frame_end    (frame_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  function automatic int unsigned clamp_size(input logic [POS_W-1:0] v, input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // one accepted input beat: shift the window, advance the position and
  // queue the normalized sum for the pixel one row and one column back
  function automatic void convolve_pixel(input logic cmd, input logic [PIX_W-1:0] pix);
    int unsigned w, h, col, rr, cc, n;
    logic [PIX_W-1:0] px, top, mid;
    logic signed [COEF_W-1:0] k;
    longint acc, q, pv, kv, nl;
    bit emit;
    conv_result_t res;
    w = clamp_size(cfg_width, MAX_WIDTH);
    h = clamp_size(cfg_height, HEIGHT_LIMIT);
    px = (cmd == CMD_DRAIN) ? '0 : pix;
    col = (in_col < MAX_WIDTH) ? in_col : MAX_WIDTH - 1;
    top = row_buf[MAX_WIDTH + col];
    mid = row_buf[col];
    row_buf[MAX_WIDTH + col] = mid;
    row_buf[col] = px;
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = px;
    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    if (in_col + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col++;
    end
    if (!emit) return;

    acc = 0;
    n = 0;
    for (int r = 0; r < 3; r++) begin
      rr = out_row + r;
      if (rr >= 1 && rr - 1 < h) begin
        for (int c = 0; c < 3; c++) begin
          cc = out_col + c;
          if (cc >= 1 && cc - 1 < w) begin
            k = coef_rows[r][c*COEF_W +: COEF_W];
            pv = win[r*3+c];
            kv = k;
            acc += pv * kv;
            n++;
          end
        end
      end
    end
    q = 0;
    if (n != 0) begin
      nl = n;
      q = acc / (nl * 4096);
    end
    if (q > 2047) q = 2047;
    if (q < -2048) q = -2048;
    res.filtered  = q[FILT_W-1:0];
    res.frame_end = (out_row + 1 >= h) && (out_col + 1 >= w);
    expected_results.push_back(res);

    if (res.frame_end) begin
      in_row = 0;
      in_col = 0;
      out_row = 0;
      out_col = 0;
    end else if (out_col + 1 >= w) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
  endfunction

  task automatic send_item(input logic cmd, input logic [PIX_W-1:0] pix);
    logic [31:0] rv;
    cfg_valid <= 1'b0;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      rv = $urandom;
      item_valid <= 1'b0;
      command <= rv[8];
      pixel <= rv[PIX_W-1:0];
      @(posedge clk);
    end
    item_valid <= 1'b1;
    command <= cmd;
    pixel <= pix;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    convolve_pixel(cmd, pix);
    items_sent++;
  endtask

  // leaves cfg_valid high; the next item beat or a settle lowers it
  task automatic write_reg(input cfg_reg_t idx, input logic [ROW_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_WIDTH:  cfg_width = data[POS_W-1:0];
      REG_HEIGHT: cfg_height = data[POS_W-1:0];
      REG_COEF0:  coef_rows[0] = data;
      REG_COEF1:  coef_rows[1] = data;
      REG_COEF2:  coef_rows[2] = data;
      default: ;
    endcase
  endtask

  // wait for the pipe to empty before touching configuration
  task automatic settle();
    item_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one full frame: pixels inside the image, drains after, optional noise
  // on the command bit; stops when the frame end has wrapped the position
  task automatic run_frame(input int unsigned noise_pct);
    int unsigned h;
    logic cmd;
    logic [31:0] rv;
    logic [PIX_W-1:0] pix;
    h = clamp_size(cfg_height, HEIGHT_LIMIT);
    do begin
      cmd = (in_row >= h) ? CMD_DRAIN : CMD_PIXEL;
      if ($urandom_range(99) < noise_pct) cmd = ~cmd;
      rv = $urandom;
      pix = rv[PIX_W-1:0];
      if (rv[31:28] == 4'h0) pix = rv[27] ? 8'hFF : 8'h00;
      send_item(cmd, pix);
    end while (!(in_row == 0 && in_col == 0 && out_row == 0 && out_col == 0));
  endtask

  function automatic logic [COEF_W-1:0] pick_coef();
    logic [31:0] rv;
    rv = $urandom;
    case (rv[31:29])
      3'd0:    return 16'h7FFF;
      3'd1:    return 16'h8000;
      3'd2:    return 16'hFFFF;
      3'd3:    return 16'h0000;
      default: return rv[COEF_W-1:0];
    endcase
  endfunction

  task automatic tiny_frame(input logic [PIX_W-1:0] pix, input logic second_cmd);
    send_item(CMD_PIXEL, pix);
    send_item(second_cmd, ~pix);
    send_item(CMD_DRAIN, 8'h00);
  endtask

  // 3x3 frame: full-scale pixels, extreme coefficients, a drain inside the
  // image and pixels where drains belong
  task automatic test_directed_frame();
    write_reg(REG_WIDTH, 48'd3);
    write_reg(REG_HEIGHT, 48'd3);
    write_reg(REG_COEF0, 48'h0001_8000_7FFF);
    write_reg(REG_COEF1, 48'h8000_1000_FFFF);
    write_reg(REG_COEF2, 48'h7FFF_7FFF_7FFF);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_item(CMD_DRAIN, 8'hFF);
      else send_item(CMD_PIXEL, (i % 3 == 1) ? 8'h00 : 8'hFF);
    end
    send_item(CMD_DRAIN, 8'h00);
    send_item(CMD_PIXEL, 8'hA5);
    send_item(CMD_DRAIN, 8'h5A);
    send_item(CMD_PIXEL, 8'hFF);
  endtask

  // single-pixel frames at the extremes of the output, and sizes of zero
  task automatic test_small_sizes();
    settle();
    write_reg(REG_WIDTH, 48'd1);
    write_reg(REG_HEIGHT, 48'd1);
    write_reg(REG_COEF1, 48'h0000_8000_0000);
    tiny_frame(8'hFF, CMD_DRAIN);
    settle();
    write_reg(REG_COEF1, 48'h0000_7FFF_0000);
    tiny_frame(8'hFF, CMD_PIXEL);
    settle();
    write_reg(REG_WIDTH, 48'hFFFF_FFFF_F800);
    write_reg(REG_HEIGHT, 48'h8000_0000_0000);
    tiny_frame(8'h80, CMD_PIXEL);
  endtask

  task automatic test_random_frames();
    int unsigned first_item, done, noise;
    logic [31:0] rv;
    logic [ROW_W-1:0] d;
    first_item = items_sent;
    done = 0;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      done = items_sent - first_item;
      if (done == 0 || $urandom_range(99) < 60) begin
        settle();
        if (done == 0 || $urandom_range(1) == 1) begin
          d = ROW_W'({$urandom, $urandom});
          rv = $urandom_range(9);
          if (rv == 0) rv = 0;
          else if (rv < 3) rv = $urandom_range(48, 13);
          else rv = $urandom_range(12, 1);
          d[POS_W-1:0] = rv[POS_W-1:0];
          write_reg(REG_WIDTH, d);
        end
        if (done == 0 || $urandom_range(1) == 1) begin
          d = ROW_W'({$urandom, $urandom});
          rv = $urandom_range(9);
          if (rv == 0) rv = 0;
          else if (rv < 3) rv = $urandom_range(12, 6);
          else rv = $urandom_range(5, 1);
          d[POS_W-1:0] = rv[POS_W-1:0];
          write_reg(REG_HEIGHT, d);
        end
        if (done == 0 || $urandom_range(1) == 1)
          write_reg(REG_COEF0, {pick_coef(), pick_coef(), pick_coef()});
        if (done == 0 || $urandom_range(1) == 1)
          write_reg(REG_COEF1, {pick_coef(), pick_coef(), pick_coef()});
        if (done == 0 || $urandom_range(1) == 1)
          write_reg(REG_COEF2, {pick_coef(), pick_coef(), pick_coef()});
      end
      // a stretch with no gaps and no stalls
      quiet = (done >= 100 && done < 250);
      noise = ($urandom_range(99) < 25) ? $urandom_range(40, 5) : 0;
      run_frame(noise);
    end
    quiet = 0;
  endtask

  // tallest column, clamped to the height limit
  task automatic test_size_limits();
    settle();
    write_reg(REG_WIDTH, 48'd1);
    write_reg(REG_HEIGHT, 48'd2047);
    write_reg(REG_COEF0, {pick_coef(), pick_coef(), pick_coef()});
    write_reg(REG_COEF1, {pick_coef(), pick_coef(), pick_coef()});
    write_reg(REG_COEF2, {pick_coef(), pick_coef(), pick_coef()});
    run_frame(0);
  endtask

  always @(posedge clk) begin
    conv_result_t exp_res;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result filtered=%0d frame_end=%0b",
                                  filtered, frame_end));
      end else begin
        exp_res = expected_results.pop_front();
        if (filtered !== exp_res.filtered)
          report_mismatch($sformatf("filtered %0d, expected %0d", filtered, exp_res.filtered));
        if (frame_end !== exp_res.frame_end)
          report_mismatch($sformatf("frame_end %0b, expected %0b", frame_end,
                                    exp_res.frame_end));
      end
    end
    result_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  initial begin
    coef_rows[0] = '0;
    coef_rows[1] = '0;
    coef_rows[2] = '0;
    for (int i = 0; i < 2*MAX_WIDTH; i++) row_buf[i] = '0;
    for (int i = 0; i < 9; i++) win[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_directed_frame();
    test_small_sizes();
    test_random_frames();
    test_size_limits();
    settle();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/c2e_pkg.sv
rtl/c2e_line_buf.sv
rtl/c2e_cell.sv
rtl/c2e_norm.sv
rtl/conv2d_edge_normalized.sv
rtl/c2e_checker.sv
dv/tb_conv2d_edge_normalized.sv
